// ----- rtl/ts_cc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_cc_pkg
// Shared types and constants for the transport stream continuity checker.
// ----------------------------------------------------------------------------
package ts_cc_pkg;

    localparam int PID_W = 13;
    localparam int CNT_W = 4;
    localparam int AFC_W = 2;
    localparam int SYNC_W = 8;

    localparam logic [SYNC_W-1:0] SYNC_VALUE = 8'h47;

    // adaptation field control codes that carry a payload
    localparam logic [AFC_W-1:0] AFC_PAYLOAD_ONLY = 2'd1;
    localparam logic [AFC_W-1:0] AFC_ADAPT_PAYLOAD = 2'd3;

    // classified packet header, front to back
    typedef struct packed {
        logic             sync_missing;
        logic             tracked;
        logic             payload;
        logic             disc;
        logic [CNT_W-1:0] rx_count;
        logic [PID_W-1:0] pid;
    } t_cmd;

    // one check result
    typedef struct packed {
        logic             sync_missing;
        logic             continuity_error;
        logic [CNT_W-1:0] expected_count;
        logic             first_seen;
        logic [PID_W-1:0] pid_echo;
    } t_res;

    // table entry: seen bit over counter
    typedef struct packed {
        logic             seen;
        logic [CNT_W-1:0] count;
    } t_entry;

endpackage

// ----- rtl/ts_cc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_cc_if
// Valid/ready channels for packet headers and check results.
// ----------------------------------------------------------------------------
interface ts_cc_pkt_if;
    logic        valid;
    logic        ready;
    logic [7:0]  sync_byte;
    logic [12:0] pid;
    logic [1:0]  adaptation_control;
    logic [3:0]  received_count;
    logic        discontinuity_flag;

    modport source (
        output valid, sync_byte, pid, adaptation_control, received_count,
               discontinuity_flag,
        input  ready
    );
    modport sink (
        input  valid, sync_byte, pid, adaptation_control, received_count,
               discontinuity_flag,
        output ready
    );
endinterface

interface ts_cc_res_if;
    logic        valid;
    logic        ready;
    logic        sync_missing;
    logic        continuity_error;
    logic [3:0]  expected_count;
    logic        first_seen;
    logic [12:0] pid_echo;

    modport source (
        output valid, sync_missing, continuity_error, expected_count, first_seen,
               pid_echo,
        input  ready
    );
    modport sink (
        input  valid, sync_missing, continuity_error, expected_count, first_seen,
               pid_echo,
        output ready
    );
endinterface

// ----- rtl/ts_cc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_cc_front
// Header classification: sync check, PID range check, payload decode.
// ----------------------------------------------------------------------------
module ts_cc_front import ts_cc_pkg::*; #(
    parameter int PID_ENTRIES = 8192
) (
    input  logic              i_valid,
    input  logic [SYNC_W-1:0] i_sync_byte,
    input  logic [PID_W-1:0]  i_pid,
    input  logic [AFC_W-1:0]  i_afc,
    input  logic [CNT_W-1:0]  i_rx_count,
    input  logic              i_disc,
    input  logic              i_queue_full,
    input  logic              i_init_done,
    output logic              o_ready,
    output logic              o_push,
    output t_cmd              o_cmd
);

    localparam logic [PID_W:0] ENTRIES = (PID_W+1)'(PID_ENTRIES);

    assign o_ready = i_init_done && !i_queue_full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_cmd.sync_missing = (i_sync_byte != SYNC_VALUE);
        o_cmd.tracked      = ({1'b0, i_pid} < ENTRIES);
        o_cmd.payload      = (i_afc == AFC_PAYLOAD_ONLY) || (i_afc == AFC_ADAPT_PAYLOAD);
        o_cmd.disc         = i_disc;
        o_cmd.rx_count     = i_rx_count;
        o_cmd.pid          = i_pid;
    end

endmodule

// ----- rtl/ts_cc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_cc_queue
// Two-entry queue of classified headers between front and back.
// ----------------------------------------------------------------------------
module ts_cc_queue import ts_cc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/ts_cc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_cc_back
// Counter table read-modify-write, table clear after reset, result register.
// ----------------------------------------------------------------------------
module ts_cc_back import ts_cc_pkg::*; #(
    parameter int PID_ENTRIES = 8192
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_pop,
    output logic o_init_done,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    localparam int AW = $clog2(PID_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PID_ENTRIES - 1);

    t_entry          r_mem [PID_ENTRIES];
    t_entry          r_rdata;
    t_cmd            r_cmd;
    logic            r_busy;
    logic            r_clearing;
    logic [AW-1:0]   r_clr_addr;
    logic            r_out_valid;
    t_res            r_res;

    logic            done;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_entry          wr_data;
    t_res            n_res;
    logic [CNT_W-1:0] upd_count;

    assign o_init_done = !r_clearing;
    assign o_pop       = i_q_valid && !r_busy && !r_clearing;
    assign done        = r_busy && (!r_out_valid || i_ready);
    assign o_valid     = r_out_valid;
    assign o_res       = r_res;

    // result and write-back value
    always_comb begin
        n_res.sync_missing     = r_cmd.sync_missing;
        n_res.pid_echo         = r_cmd.pid;
        n_res.continuity_error = 1'b0;
        n_res.first_seen       = 1'b0;
        n_res.expected_count   = '0;
        upd_count              = r_cmd.rx_count;
        if (r_cmd.sync_missing) begin
            n_res.expected_count = '0;
        end else if (!r_cmd.tracked) begin
            n_res.expected_count = r_cmd.rx_count;
        end else begin
            if (!r_rdata.seen) begin
                n_res.first_seen     = 1'b1;
                n_res.expected_count = r_cmd.rx_count;
            end else begin
                n_res.expected_count = r_rdata.count + CNT_W'(r_cmd.payload);
            end
            n_res.continuity_error = !r_cmd.disc &&
                                     (n_res.expected_count != r_cmd.rx_count);
            upd_count = n_res.continuity_error ? r_cmd.rx_count
                                               : n_res.expected_count;
        end
    end

    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = done && r_cmd.tracked && !r_cmd.sync_missing;
            wr_addr = r_cmd.pid[AW-1:0];
            wr_data = '{seen: 1'b1, count: upd_count};
        end
    end

    // table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (o_pop) begin
            r_rdata <= r_mem[i_q_cmd.pid[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (done) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_no_pop_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_pop)
        else $error("item taken during table clear");

    a_pop_write_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_pop && wr_en))
        else $error("table read issued while writing back");

    a_busy_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_out_valid) |=> (!r_busy && r_out_valid))
        else $error("item in check stage did not complete");

    a_sync_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.sync_missing) |->
            (!r_res.continuity_error && !r_res.first_seen))
        else $error("sync-missing result carries check flags");

endmodule

// ----- rtl/ts_continuity_counter_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_continuity_counter_check
// Per-PID MPEG-TS continuity counter checker.
// ----------------------------------------------------------------------------
// Usage:
//   i_pkt carries one packet header item (sync byte, PID, adaptation control,
//   continuity counter, discontinuity flag); o_res returns exactly one result
//   item per header, in order. Both are valid/ready channels.
//   The front classifies a header in the accept cycle and drops it into a
//   two-entry queue. The back reads the PID's table entry (registered read),
//   then, once the result register can be loaded, checks, writes the entry
//   back and loads the result register. The back stage takes a new item
//   only after the previous one has written its entry back.
//   Reset: after i_rst_n is released the table is swept to "unseen", one
//   entry per cycle; i_pkt.ready stays low meanwhile.
//   When the receiver stalls, the result register holds, the back stops,
//   and the queue absorbs up to two more headers before i_pkt.ready drops.
//   PIDs at or above PID_ENTRIES are passed through unchecked.
// ----------------------------------------------------------------------------
module ts_continuity_counter_check import ts_cc_pkg::*; #(
    parameter int PID_ENTRIES = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ts_cc_pkt_if.sink   i_pkt,
    ts_cc_res_if.source o_res
);

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic front_push;
    logic q_full;
    logic q_valid;
    logic back_pop;
    logic init_done;
    logic res_valid;
    t_res res;

    // accept and classify
    ts_cc_front #(
        .PID_ENTRIES (PID_ENTRIES)
    ) u_front (
        .i_valid      (i_pkt.valid),
        .i_sync_byte  (i_pkt.sync_byte),
        .i_pid        (i_pkt.pid),
        .i_afc        (i_pkt.adaptation_control),
        .i_rx_count   (i_pkt.received_count),
        .i_disc       (i_pkt.discontinuity_flag),
        .i_queue_full (q_full),
        .i_init_done  (init_done),
        .o_ready      (i_pkt.ready),
        .o_push       (front_push),
        .o_cmd        (front_cmd)
    );

    // decouples header intake from table work
    ts_cc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // table lookup, check, write-back, result register
    ts_cc_back #(
        .PID_ENTRIES (PID_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (back_pop),
        .o_init_done (init_done),
        .o_valid     (res_valid),
        .i_ready     (o_res.ready),
        .o_res       (res)
    );

    assign o_res.valid            = res_valid;
    assign o_res.sync_missing     = res.sync_missing;
    assign o_res.continuity_error = res.continuity_error;
    assign o_res.expected_count   = res.expected_count;
    assign o_res.first_seen       = res.first_seen;
    assign o_res.pid_echo         = res.pid_echo;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-PID continuity counter checker.
// A short table of hand-built headers runs first, most of them with verdicts
// typed in. Random streams follow: several live PIDs with mostly correct
// counters, plus broken counters, discontinuities, bad sync bytes and random
// noise. A shadow PID table predicts every verdict not typed in. Results
// are compared in order, field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import ts_cc_pkg::*;

    localparam int TRACKED_PIDS  = 8192;
    localparam int RANDOM_ITEMS  = 1830;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 150;
    localparam int IDLE_PERCENT  = 26;
    localparam int POOL_SIZE     = 8;

    // adaptation field control codes without a payload
    localparam logic [AFC_W-1:0] AFC_RESERVED   = 2'd0;
    localparam logic [AFC_W-1:0] AFC_ADAPT_ONLY = 2'd2;

    // one header to send; verdict is used only when typed is set
    typedef struct {
        logic [SYNC_W-1:0] sync;
        logic [PID_W-1:0]  pid;
        logic [AFC_W-1:0]  afc;
        logic [CNT_W-1:0]  rx;
        logic              disc;
        bit                typed;
        t_res              verdict;
    } t_hdr_row;

    logic i_clk;
    logic i_rst_n;

    ts_cc_pkt_if pkt_ch ();
    ts_cc_res_if res_ch ();

    ts_continuity_counter_check #(
        .PID_ENTRIES (TRACKED_PIDS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_ch),
        .o_res   (res_ch)
    );

    // shadow of the PID table
    t_entry   pid_state [TRACKED_PIDS];
    // headers on the input, in order, waiting to be taken
    t_hdr_row offered_rows [$];
    // verdicts owed by the block, oldest first
    t_res     cc_verdicts_due [$];

    int  mismatches     = 0;
    int  cycles         = 0;
    int  headers_taken  = 0;
    int  results_seen   = 0;
    int  cc_errors_seen = 0;
    int  first_seen_cnt = 0;
    int  no_sync_cnt    = 0;

    // sender -> receiver coordination
    bit  steady_run = 1'b0;
    int  hold_req   = 0;
    int  hold_taken = 0;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d verdicts still owed",
                     $time, cycles, cc_verdicts_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: one verdict per header, updates the shadow table
    // ------------------------------------------------------------------
    function automatic t_res check_continuity(input logic [SYNC_W-1:0] sync,
                                              input logic [PID_W-1:0]  pid,
                                              input logic [AFC_W-1:0]  afc,
                                              input logic [CNT_W-1:0]  rx,
                                              input logic              disc);
        t_res   r;
        t_entry e;
        r          = '0;
        r.pid_echo = pid;
        // no sync byte: flagged, table untouched
        if (sync != SYNC_VALUE) begin
            r.sync_missing = 1'b1;
            return r;
        end
        r.expected_count = rx;
        // untracked PIDs pass with the received counter
        if (int'(pid) < TRACKED_PIDS) begin
            e = pid_state[pid];
            if (!e.seen) begin
                r.first_seen = 1'b1;
            end else begin
                r.expected_count = e.count;
                if (afc == AFC_PAYLOAD_ONLY || afc == AFC_ADAPT_PAYLOAD)
                    r.expected_count = e.count + 1'b1;
            end
            // mismatch without discontinuity: error, resync to received;
            // with discontinuity the advanced counter is kept
            if (!disc && r.expected_count != rx) begin
                r.continuity_error = 1'b1;
                pid_state[pid]     = '{1'b1, rx};
            end else begin
                pid_state[pid] = '{1'b1, r.expected_count};
            end
        end
        return r;
    endfunction

    function automatic t_hdr_row header_row(input logic [SYNC_W-1:0] sync,
                                            input logic [PID_W-1:0]  pid,
                                            input logic [AFC_W-1:0]  afc,
                                            input logic [CNT_W-1:0]  rx,
                                            input logic              disc,
                                            input bit                typed,
                                            input logic              v_nosync,
                                            input logic              v_err,
                                            input logic [CNT_W-1:0]  v_exp,
                                            input logic              v_first);
        t_hdr_row h;
        h.sync    = sync;
        h.pid     = pid;
        h.afc     = afc;
        h.rx      = rx;
        h.disc    = disc;
        h.typed   = typed;
        h.verdict = '{v_nosync, v_err, v_exp, v_first, pid};
        return h;
    endfunction

    function automatic void cmp_field(input string fld, input logic [15:0] want,
                                      input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d got %0d", $time, fld, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side: predict at each accepted header
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : hdr_watch
        t_hdr_row row;
        t_res     want;
        if (!i_rst_n) begin
            foreach (pid_state[p]) pid_state[p] = '0;
        end else if (pkt_ch.valid && pkt_ch.ready) begin
            row  = offered_rows.pop_front();
            want = check_continuity(pkt_ch.sync_byte, pkt_ch.pid, pkt_ch.adaptation_control,
                                    pkt_ch.received_count, pkt_ch.discontinuity_flag);
            // hand-typed verdicts take the place of the prediction
            if (row.typed) want = row.verdict;
            cc_verdicts_due.push_back(want);
            headers_taken++;
        end
    end

    // ------------------------------------------------------------------
    // Output side: compare each accepted result with the oldest verdict
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : res_watch
        t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (res_ch.continuity_error) cc_errors_seen++;
            if (res_ch.first_seen)       first_seen_cnt++;
            if (res_ch.sync_missing)     no_sync_cnt++;
            if (cc_verdicts_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got pid %0d cc %0d",
                         $time, res_ch.pid_echo, res_ch.expected_count);
                mismatches++;
            end else begin
                want = cc_verdicts_due.pop_front();
                cmp_field("sync_missing", 16'(want.sync_missing),
                          16'(res_ch.sync_missing));
                cmp_field("continuity_error", 16'(want.continuity_error),
                          16'(res_ch.continuity_error));
                cmp_field("expected_count", 16'(want.expected_count),
                          16'(res_ch.expected_count));
                cmp_field("first_seen", 16'(want.first_seen), 16'(res_ch.first_seen));
                cmp_field("pid_echo", 16'(want.pid_echo), 16'(res_ch.pid_echo));
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, one long hold-off on request,
    // no stalls during the steady stretch
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_taken != hold_req) begin
                hold_taken = hold_req;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one header; returns at the edge that takes it, valid still high.
    task automatic offer_header(input t_hdr_row h);
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
            pkt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pkt_ch.valid              <= 1'b1;
        pkt_ch.sync_byte          <= h.sync;
        pkt_ch.pid                <= h.pid;
        pkt_ch.adaptation_control <= h.afc;
        pkt_ch.received_count     <= h.rx;
        pkt_ch.discontinuity_flag <= h.disc;
        offered_rows.push_back(h);
        @(posedge i_clk);
        while (!pkt_ch.ready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every owed verdict has come back.
    task automatic wait_drained();
        pkt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (cc_verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_hdr_row         plan [$];
        t_hdr_row         h;
        logic [PID_W-1:0] pool_pid  [POOL_SIZE];
        logic [CNT_W-1:0] pool_cc   [POOL_SIZE];
        bit               pool_live [POOL_SIZE];
        int               pick;
        int               roll;

        i_rst_n                   <= 1'b0;
        pkt_ch.valid              <= 1'b0;
        pkt_ch.sync_byte          <= '0;
        pkt_ch.pid                <= '0;
        pkt_ch.adaptation_control <= '0;
        pkt_ch.received_count     <= '0;
        pkt_ch.discontinuity_flag <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the table sweep after reset holds ready low; offer_header waits it out

        // --- directed headers -------------------------------------------
        // PID 0: first sighting, in-order counters, no-payload hold,
        // continuity error and resync, discontinuity with mismatch
        plan.push_back(header_row(SYNC_VALUE, 13'd0, AFC_PAYLOAD_ONLY, 4'd5, 1'b0,
                                  1, 1'b0, 1'b0, 4'd5, 1'b1));
        plan.push_back(header_row(SYNC_VALUE, 13'd0, AFC_PAYLOAD_ONLY, 4'd6, 1'b0,
                                  1, 1'b0, 1'b0, 4'd6, 1'b0));
        plan.push_back(header_row(SYNC_VALUE, 13'd0, AFC_RESERVED, 4'd6, 1'b0,
                                  1, 1'b0, 1'b0, 4'd6, 1'b0));
        plan.push_back(header_row(SYNC_VALUE, 13'd0, AFC_ADAPT_ONLY, 4'd7, 1'b0,
                                  1, 1'b0, 1'b1, 4'd6, 1'b0));
        plan.push_back(header_row(SYNC_VALUE, 13'd0, AFC_ADAPT_PAYLOAD, 4'd8, 1'b0,
                                  1, 1'b0, 1'b0, 4'd8, 1'b0));
        // discontinuity: no error, table keeps 9 rather than 3
        plan.push_back(header_row(SYNC_VALUE, 13'd0, AFC_PAYLOAD_ONLY, 4'd3, 1'b1,
                                  1, 1'b0, 1'b0, 4'd9, 1'b0));
        plan.push_back(header_row(SYNC_VALUE, 13'd0, AFC_PAYLOAD_ONLY, 4'd10, 1'b0,
                                  1, 1'b0, 1'b0, 4'd10, 1'b0));
        // missing sync byte: flagged, nothing else, table unchanged
        plan.push_back(header_row(8'h00, 13'h1FFF, AFC_ADAPT_PAYLOAD, 4'd15, 1'b1,
                                  1, 1'b1, 1'b0, 4'd0, 1'b0));
        plan.push_back(header_row(8'hFF, 13'd0, AFC_PAYLOAD_ONLY, 4'd0, 1'b0,
                                  1, 1'b1, 1'b0, 4'd0, 1'b0));
        plan.push_back(header_row(8'h46, 13'd0, AFC_PAYLOAD_ONLY, 4'd11, 1'b0,
                                  1, 1'b1, 1'b0, 4'd0, 1'b0));
        plan.push_back(header_row(SYNC_VALUE, 13'd0, AFC_PAYLOAD_ONLY, 4'd11, 1'b0,
                                  1, 1'b0, 1'b0, 4'd11, 1'b0));
        // top PID: counter wraps 15 -> 0, then an error, then no payload
        plan.push_back(header_row(SYNC_VALUE, 13'h1FFF, AFC_PAYLOAD_ONLY, 4'd15, 1'b0,
                                  1, 1'b0, 1'b0, 4'd15, 1'b1));
        plan.push_back(header_row(SYNC_VALUE, 13'h1FFF, AFC_PAYLOAD_ONLY, 4'd0, 1'b0,
                                  1, 1'b0, 1'b0, 4'd0, 1'b0));
        plan.push_back(header_row(SYNC_VALUE, 13'h1FFF, AFC_PAYLOAD_ONLY, 4'd0, 1'b0,
                                  1, 1'b0, 1'b1, 4'd1, 1'b0));
        plan.push_back(header_row(SYNC_VALUE, 13'h1FFF, AFC_RESERVED, 4'd0, 1'b1,
                                  1, 1'b0, 1'b0, 4'd0, 1'b0));
        // alternating PID bit patterns
        plan.push_back(header_row(SYNC_VALUE, 13'h1555, AFC_RESERVED, 4'd0, 1'b1,
                                  1, 1'b0, 1'b0, 4'd0, 1'b1));
        plan.push_back(header_row(SYNC_VALUE, 13'h0AAA, AFC_ADAPT_ONLY, 4'd15, 1'b1,
                                  1, 1'b0, 1'b0, 4'd15, 1'b1));
        plan.push_back(header_row(SYNC_VALUE, 13'h0AAA, AFC_ADAPT_ONLY, 4'd15, 1'b0,
                                  1, 1'b0, 1'b0, 4'd15, 1'b0));
        plan.push_back(header_row(SYNC_VALUE, 13'h1555, AFC_ADAPT_PAYLOAD, 4'd1, 1'b0,
                                  1, 1'b0, 1'b0, 4'd1, 1'b0));
        plan.push_back(header_row(SYNC_VALUE, 13'h1555, AFC_ADAPT_PAYLOAD, 4'd9, 1'b1,
                                  1, 1'b0, 1'b0, 4'd2, 1'b0));
        plan.push_back(header_row(SYNC_VALUE, 13'h1555, AFC_PAYLOAD_ONLY, 4'd3, 1'b0,
                                  1, 1'b0, 1'b0, 4'd3, 1'b0));
        // predictor-checked rows
        plan.push_back(header_row(SYNC_VALUE, 13'h1000, AFC_PAYLOAD_ONLY, 4'd4, 1'b0,
                                  0, 1'b0, 1'b0, 4'd0, 1'b0));
        plan.push_back(header_row(SYNC_VALUE, 13'h1000, AFC_ADAPT_PAYLOAD, 4'd2, 1'b0,
                                  0, 1'b0, 1'b0, 4'd0, 1'b0));
        plan.push_back(header_row(SYNC_VALUE, 13'h0001, AFC_ADAPT_ONLY, 4'd12, 1'b1,
                                  0, 1'b0, 1'b0, 4'd0, 1'b0));
        foreach (plan[i]) offer_header(plan[i]);
        wait_drained();

        // --- random streams ----------------------------------------------
        // a small pool of live PIDs so most headers hit stored counters
        for (int p = 0; p < POOL_SIZE; p++) begin
            pool_pid[p]  = PID_W'($urandom_range(TRACKED_PIDS - 1));
            pool_live[p] = 1'b0;
            pool_cc[p]   = '0;
        end
        pool_pid[0] = '0;
        pool_pid[1] = '1;

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // receiver backs off for a long stretch while headers keep coming
            if (k == 300) hold_req++;
            // sender pauses until everything has come back
            if (k == 500 || k == 1400) wait_drained();
            steady_run = (k >= 900 && k < 1100);

            h.typed   = 1'b0;
            h.verdict = '0;
            roll      = $urandom_range(99);
            if (roll < 8) begin
                // broken sync byte on an arbitrary PID
                h.sync = SYNC_W'($urandom_range(255));
                if (h.sync == SYNC_VALUE) h.sync ^= 8'h01;
                h.pid  = PID_W'($urandom_range(TRACKED_PIDS - 1));
                h.afc  = AFC_W'($urandom_range(3));
                h.rx   = CNT_W'($urandom_range(15));
                h.disc = 1'($urandom_range(1));
            end else if (roll < 14) begin
                // pure noise, every field random
                h.sync = SYNC_W'($urandom_range(255));
                h.pid  = PID_W'($urandom_range(8191));
                h.afc  = AFC_W'($urandom_range(3));
                h.rx   = CNT_W'($urandom_range(15));
                h.disc = 1'($urandom_range(1));
            end else begin
                // stream traffic on a pool PID, now and then a new PID
                pick = $urandom_range(POOL_SIZE - 1);
                if ($urandom_range(99) < 2) begin
                    pool_pid[pick]  = PID_W'($urandom_range(8191));
                    pool_live[pick] = 1'b0;
                end
                h.sync = SYNC_VALUE;
                h.pid  = pool_pid[pick];
                h.afc  = ($urandom_range(99) < 75) ?
                         (($urandom_range(1) != 0) ? AFC_PAYLOAD_ONLY : AFC_ADAPT_PAYLOAD) :
                         (($urandom_range(1) != 0) ? AFC_RESERVED : AFC_ADAPT_ONLY);
                h.disc = ($urandom_range(99) < 10);
                if (!pool_live[pick] || $urandom_range(99) < 8)
                    h.rx = CNT_W'($urandom_range(15));
                else if (h.afc == AFC_PAYLOAD_ONLY || h.afc == AFC_ADAPT_PAYLOAD)
                    h.rx = pool_cc[pick] + 1'b1;
                else
                    h.rx = pool_cc[pick];
                pool_cc[pick]   = h.rx;
                pool_live[pick] = 1'b1;
            end
            offer_header(h);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Run: %0d headers checked, %0d results (%0d continuity errors,",
                 headers_taken, results_seen, cc_errors_seen);
        $display("     %0d first sightings, %0d missing sync bytes)",
                 first_seen_cnt, no_sync_cnt);
        if (mismatches == 0 && cc_verdicts_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ts_cc_pkg.sv
rtl/ts_cc_if.sv
rtl/ts_cc_front.sv
rtl/ts_cc_queue.sv
rtl/ts_cc_back.sv
rtl/ts_continuity_counter_check.sv
bench/testbench.sv
